### design/mwc_rrg_pkg.sv
// Package for the multiply-with-carry random range generator.
// Types, action codes, generator constants and controller/datapath structs.
// No dependencies.
`default_nettype none

package mwc_rrg_pkg;

    localparam int ACT_W   = 2;
    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;

    typedef logic [ACT_W-1:0]         t_action;
    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [WORD_W-1:0] t_sword;
    typedef logic [HALF_W-1:0]        t_half;

    localparam t_action ACT_RAW   = 2'd0;
    localparam t_action ACT_RANGE = 2'd1;
    localparam t_action ACT_FRAC  = 2'd2;

    localparam t_half UPPER_MULT = 16'd36969;
    localparam t_half LOWER_MULT = 16'd18000;
    localparam t_word SIGN_BIT   = 32'h8000_0000;
    localparam t_word LAG_RESET  = 32'd1;

    // remainder unit retires one dividend bit per step
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;    // request accepted: latch fields, advance generator if the action draws
        logic step;    // one remainder iteration
        logic finish;  // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;  // latched request needs the remainder unit
    } t_dp_sts;

endpackage

`default_nettype wire

### design/mwc_rrg_if.sv
// Handshake interfaces for the request and result channels.
// Depends on mwc_rrg_pkg.
`default_nettype none

interface mwc_rrg_req_if;
    logic                 valid;
    logic                 ready;
    mwc_rrg_pkg::t_action action;
    mwc_rrg_pkg::t_sword  range_min;
    mwc_rrg_pkg::t_sword  range_max;

    modport source (output valid, output action, output range_min, output range_max,
                    input ready);
    modport sink   (input valid, input action, input range_min, input range_max,
                    output ready);
endinterface

interface mwc_rrg_rsp_if;
    logic                valid;
    logic                ready;
    mwc_rrg_pkg::t_word  raw_word;
    mwc_rrg_pkg::t_sword ranged_value;
    mwc_rrg_pkg::t_sword signed_fraction;
    logic                range_error;

    modport source (output valid, output raw_word, output ranged_value,
                    output signed_fraction, output range_error, input ready);
    modport sink   (input valid, input raw_word, input ranged_value,
                    input signed_fraction, input range_error, output ready);
endinterface

`default_nettype wire

### design/mwc_rrg_ctrl.sv
// Controller FSM: accept, prepare, iterate remainder, hand result to output register.
// Depends on mwc_rrg_pkg.
`default_nettype none

module mwc_rrg_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    input  wire                  i_rsp_ready,
    input  mwc_rrg_pkg::t_dp_sts i_sts,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    output mwc_rrg_pkg::t_dp_cmd o_cmd
);
    import mwc_rrg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_out_free  = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                n_cnt   = '0;
                n_state = i_sts.need_div ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### design/mwc_rrg_dp.sv
// Datapath: generator words, draw, bounds checks, bit-serial remainder, result register.
// Depends on mwc_rrg_pkg.
`default_nettype none

module mwc_rrg_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mwc_rrg_pkg::t_action i_action,
    input  mwc_rrg_pkg::t_sword  i_range_min,
    input  mwc_rrg_pkg::t_sword  i_range_max,
    input  mwc_rrg_pkg::t_dp_cmd i_cmd,
    output mwc_rrg_pkg::t_dp_sts o_sts,
    output mwc_rrg_pkg::t_word   o_raw_word,
    output mwc_rrg_pkg::t_sword  o_ranged_value,
    output mwc_rrg_pkg::t_sword  o_signed_fraction,
    output logic                 o_range_error
);
    import mwc_rrg_pkg::*;

    t_word   r_upper, r_lower;
    t_action r_act;
    t_word   r_lo, r_draw, r_span, r_rem, r_dvd;
    logic    r_err, r_eq, r_need_div;
    t_word   r_out_raw, r_out_ranged, r_out_frac;
    logic    r_out_err;

    t_word         w_up_prod, w_lo_prod, n_upper, n_lower, w_draw;
    logic          w_gt, w_eq, w_adv;
    logic [WORD_W:0] w_rem_sh;
    t_word         n_rem, w_offset, w_ranged;

    // generator update, one 16x16 constant multiply per word
    assign w_up_prod = WORD_W'(r_upper[HALF_W-1:0]) * WORD_W'(UPPER_MULT);
    assign w_lo_prod = WORD_W'(r_lower[HALF_W-1:0]) * WORD_W'(LOWER_MULT);
    assign n_upper   = w_up_prod + WORD_W'(r_upper[WORD_W-1:HALF_W]);
    assign n_lower   = w_lo_prod + WORD_W'(r_lower[WORD_W-1:HALF_W]);
    assign w_draw    = {n_upper[HALF_W-1:0], n_lower[HALF_W-1:0]};

    assign w_gt  = i_range_min > i_range_max;
    assign w_eq  = i_range_min == i_range_max;
    assign w_adv = (i_action == ACT_RAW) || (i_action == ACT_FRAC) ||
                   ((i_action == ACT_RANGE) && !w_gt && !w_eq);

    // restoring remainder step
    assign w_rem_sh = {r_rem, r_dvd[WORD_W-1]};
    assign n_rem    = (w_rem_sh >= {1'b0, r_span}) ? WORD_W'(w_rem_sh - {1'b0, r_span})
                                                   : w_rem_sh[WORD_W-1:0];

    // span of zero means the full 32-bit range
    assign w_offset = (r_span == '0) ? r_draw : r_rem;
    assign w_ranged = r_err ? '0 : (r_eq ? r_lo : r_lo + w_offset);

    assign o_sts.need_div = r_need_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= LAG_RESET;
            r_lower <= LAG_RESET;
        end else if (i_cmd.load && w_adv) begin
            r_upper <= n_upper;
            r_lower <= n_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_lo       <= t_word'(i_range_min);
            r_span     <= t_word'(i_range_max) - t_word'(i_range_min) + 1'b1;
            r_draw     <= w_adv ? w_draw : '0;
            r_dvd      <= w_draw;
            r_rem      <= '0;
            r_err      <= (i_action == ACT_RANGE) && w_gt;
            r_eq       <= w_eq;
            r_need_div <= (i_action == ACT_RANGE) && w_adv;
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_raw    <= r_draw;
            r_out_ranged <= (r_act == ACT_RANGE) ? w_ranged : '0;
            r_out_frac   <= (r_act == ACT_FRAC) ? (r_draw ^ SIGN_BIT) : '0;
            r_out_err    <= r_err;
        end
    end

    assign o_raw_word        = r_out_raw;
    assign o_ranged_value    = t_sword'(r_out_ranged);
    assign o_signed_fraction = t_sword'(r_out_frac);
    assign o_range_error     = r_out_err;

endmodule

`default_nettype wire

### design/mwc_random_range_generator_top.sv
// Multiply-with-carry random range generator, top level.
// Request channel i_req (sink): action, range_min, range_max.
// Result channel o_rsp (source): raw_word, ranged_value, signed_fraction,
// range_error. One result per request, in request order.
// A request is taken when valid and ready are high at a rising edge; one
// request is in work at a time. Actions 0 and 2, action 1 with equal or
// reversed bounds, and the unused code skip the remainder unit and go from
// the prepare state straight to the finish state. Action 1 with a real span
// runs a bit-serial remainder unit over every bit of the draw before the
// finish state; the next request is taken only once the result is loaded.
// The result sits in an output register: a new request is taken while it
// waits, and if the receiver stalls, the next result holds in the datapath
// until the output register frees.
// Reset (synchronous, active low) sets both generator words to 1 and
// empties the block.
// Depends on mwc_rrg_pkg, mwc_rrg_if, mwc_rrg_ctrl, mwc_rrg_dp.
`default_nettype none

module mwc_random_range_generator_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mwc_rrg_req_if.sink   i_req,
    mwc_rrg_rsp_if.source o_rsp
);
    import mwc_rrg_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mwc_rrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    mwc_rrg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_action          (i_req.action),
        .i_range_min       (i_req.range_min),
        .i_range_max       (i_req.range_max),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_raw_word        (o_rsp.raw_word),
        .o_ranged_value    (o_rsp.ranged_value),
        .o_signed_fraction (o_rsp.signed_fraction),
        .o_range_error     (o_rsp.range_error)
    );

`ifndef ASSERT_OFF
    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_rsp.valid)
        else $error("result register not valid after finish");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !i_req.ready)
        else $error("request taken while one is in work");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.range_error) |->
            (o_rsp.raw_word == '0 && o_rsp.ranged_value == '0 &&
             o_rsp.signed_fraction == '0))
        else $error("reversed bounds result carries data");
`endif

endmodule

`default_nettype wire

### dv/mwc_rrg_checker.sv
// Result checker for the multiply-with-carry random range generator.
// Watches both channels, predicts each result and compares it field by field.
// Depends on mwc_rrg_pkg.

module mwc_rrg_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    input  wire                  i_req_ready,
    input  mwc_rrg_pkg::t_action i_action,
    input  mwc_rrg_pkg::t_sword  i_range_min,
    input  mwc_rrg_pkg::t_sword  i_range_max,
    input  wire                  i_rsp_valid,
    input  wire                  i_rsp_ready,
    input  mwc_rrg_pkg::t_word   i_raw_word,
    input  mwc_rrg_pkg::t_sword  i_ranged_value,
    input  mwc_rrg_pkg::t_sword  i_signed_fraction,
    input  wire                  i_range_error,
    output int unsigned          o_mismatch_count,
    output int unsigned          o_outstanding
);
    import mwc_rrg_pkg::*;

    typedef struct packed {
        t_word  raw_word;
        t_sword ranged_value;
        t_sword signed_fraction;
        logic   range_error;
    } t_draw_result;

    t_word        upper_lag;
    t_word        lower_lag;
    t_draw_result pending_draws[$];
    int unsigned  mismatch_count;

    initial begin
        upper_lag        = LAG_RESET;
        lower_lag        = LAG_RESET;
        mismatch_count   = 0;
        o_mismatch_count = 0;
        o_outstanding    = 0;
    end

    // advances both lag words and forms the draw
    function automatic t_word next_draw();
        upper_lag = t_word'(UPPER_MULT) * t_word'(upper_lag[15:0]) + t_word'(upper_lag[31:16]);
        lower_lag = t_word'(LOWER_MULT) * t_word'(lower_lag[15:0]) + t_word'(lower_lag[31:16]);
        return {upper_lag[15:0], lower_lag[15:0]};
    endfunction

    function automatic t_draw_result predict_draw(t_action act, t_sword lo, t_sword hi);
        t_draw_result res;
        t_word        span;
        res  = '0;
        span = t_word'(hi) - t_word'(lo) + 32'd1;
        case (act)
            ACT_RAW: begin
                res.raw_word = next_draw();
            end
            ACT_RANGE: begin
                if (lo > hi) begin
                    res.range_error = 1'b1;
                end else if (lo == hi) begin
                    res.ranged_value = lo;
                end else begin
                    res.raw_word = next_draw();
                    // span of zero means the whole 32-bit range
                    res.ranged_value = t_sword'(t_word'(lo) +
                        ((span == '0) ? res.raw_word : res.raw_word % span));
                end
            end
            ACT_FRAC: begin
                res.raw_word        = next_draw();
                res.signed_fraction = t_sword'(res.raw_word ^ SIGN_BIT);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : track_draws
        t_draw_result want;
        t_draw_result got;
        if (!i_rst_n) begin
            upper_lag = LAG_RESET;
            lower_lag = LAG_RESET;
            pending_draws.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = '{i_raw_word, i_ranged_value, i_signed_fraction, i_range_error};
                if (pending_draws.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result with no request outstanding: raw=%h ranged=%h",
                                 $time, got.raw_word, got.ranged_value);
                    mismatch_count++;
                end else begin
                    want = pending_draws.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  want raw=%h ranged=%h frac=%h err=%b", want.raw_word,
                                     want.ranged_value, want.signed_fraction, want.range_error);
                            $display("  got  raw=%h ranged=%h frac=%h err=%b", got.raw_word,
                                     got.ranged_value, got.signed_fraction, got.range_error);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                pending_draws.push_back(predict_draw(i_action, i_range_min, i_range_max));
        end
        o_mismatch_count <= mismatch_count;
        o_outstanding    <= pending_draws.size();
    end

endmodule

### dv/tb_top.sv
// Testbench top for the multiply-with-carry random range generator.
// Drives requests and result back-pressure, gives the verdict.
// Depends on mwc_rrg_pkg, mwc_rrg_if, mwc_rrg_checker and the block's RTL.

module tb_top;
    import mwc_rrg_pkg::*;

    localparam t_action     ACT_UNUSED     = 2'd3;
    localparam t_sword      WORD_MIN       = 32'sh8000_0000;
    localparam t_sword      WORD_MAX       = 32'sh7fff_ffff;
    localparam int unsigned RANDOM_ITEMS   = 380;
    localparam int unsigned HOLD_AT        = 150;
    localparam int unsigned CALM_TAIL      = 60;
    localparam int unsigned LONG_HOLD      = 120;
    localparam int unsigned DRAIN_CYCLES   = 50;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          idling_on;
    bit          hold_off_start;
    int unsigned mismatch_count;
    int unsigned draws_outstanding;
    int unsigned quiet_cycles;

    mwc_rrg_req_if req_bus();
    mwc_rrg_rsp_if rsp_bus();

    mwc_random_range_generator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    mwc_rrg_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (req_bus.valid),
        .i_req_ready       (req_bus.ready),
        .i_action          (req_bus.action),
        .i_range_min       (req_bus.range_min),
        .i_range_max       (req_bus.range_max),
        .i_rsp_valid       (rsp_bus.valid),
        .i_rsp_ready       (rsp_bus.ready),
        .i_raw_word        (rsp_bus.raw_word),
        .i_ranged_value    (rsp_bus.ranged_value),
        .i_signed_fraction (rsp_bus.signed_fraction),
        .i_range_error     (rsp_bus.range_error),
        .o_mismatch_count  (mismatch_count),
        .o_outstanding     (draws_outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // offers one request, waits for the edge that takes it, and may then drop valid and idle with random fields
    task automatic send_request(input t_action act, input t_sword lo, input t_sword hi);
        req_bus.valid     <= 1'b1;
        req_bus.action    <= act;
        req_bus.range_min <= lo;
        req_bus.range_max <= hi;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_bus.valid     <= 1'b0;
            req_bus.action    <= t_action'($urandom);
            req_bus.range_min <= t_sword'($urandom);
            req_bus.range_max <= t_sword'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_request();
        t_action     act;
        t_sword      lo;
        t_sword      hi;
        t_sword      a;
        t_sword      b;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)       act = ACT_RAW;
        else if (pick < 15) act = ACT_RANGE;
        else if (pick < 19) act = ACT_FRAC;
        else                act = ACT_UNUSED;
        a  = t_sword'($urandom);
        b  = t_sword'($urandom);
        lo = a;
        hi = b;
        if (act == ACT_RANGE) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if ($urandom_range(0, 1) == 0)
                        lo = t_sword'($urandom_range(0, 2000)) - 32'sd1000;
                    // may wrap past the top, which reverses the bounds
                    hi = lo + t_sword'($urandom_range(1, 300));
                end
                4, 5: begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
                6: begin
                    hi = lo;
                end
                7: begin
                    lo = (a > b) ? a : b;
                    hi = (a > b) ? b : a;
                end
                8: begin
                    case ($urandom_range(0, 3))
                        0: lo = WORD_MIN;
                        1: lo = -32'sd1;
                        2: lo = 32'sd0;
                        default: lo = a;
                    endcase
                    case ($urandom_range(0, 2))
                        0: hi = WORD_MAX;
                        1: hi = 32'sd0;
                        default: hi = b;
                    endcase
                end
                default: begin
                    hi = lo + t_sword'((32'd1 << $urandom_range(1, 31)) - 32'd1);
                end
            endcase
        end
        send_request(act, lo, hi);
    endtask

    initial begin : result_sink
        int unsigned burst_left;
        int unsigned hold_left;
        burst_left = 0;
        hold_left  = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_start) begin
                hold_off_start = 1'b0;
                hold_left      = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                rsp_bus.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 2);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : request_source
        idling_on      = 1'b1;
        hold_off_start = 1'b0;
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.action    <= ACT_RAW;
        req_bus.range_min <= '0;
        req_bus.range_max <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(ACT_RAW, 32'sd0, 32'sd0);
        send_request(ACT_RAW, WORD_MAX, WORD_MIN);
        send_request(ACT_FRAC, 32'sd0, 32'sd0);
        send_request(ACT_FRAC, WORD_MIN, WORD_MAX);
        send_request(ACT_UNUSED, WORD_MIN, WORD_MAX);
        send_request(ACT_UNUSED, -32'sd1, -32'sd1);
        // equal bounds: no draw
        send_request(ACT_RANGE, 32'sd5, 32'sd5);
        send_request(ACT_RANGE, WORD_MIN, WORD_MIN);
        send_request(ACT_RANGE, WORD_MAX, WORD_MAX);
        // reversed bounds: error, no draw
        send_request(ACT_RANGE, 32'sd10, -32'sd10);
        send_request(ACT_RANGE, WORD_MAX, WORD_MIN);
        send_request(ACT_RANGE, 32'sd0, -32'sd1);
        // full span wraps to zero
        send_request(ACT_RANGE, WORD_MIN, WORD_MAX);
        send_request(ACT_RANGE, WORD_MIN, WORD_MAX - 32'sd1);
        send_request(ACT_RANGE, WORD_MIN + 32'sd1, WORD_MAX);
        send_request(ACT_RANGE, 32'sd0, 32'sd1);
        send_request(ACT_RANGE, -32'sd1, 32'sd0);
        send_request(ACT_RANGE, -32'sd5, 32'sd5);
        send_request(ACT_RANGE, WORD_MIN, WORD_MIN + 32'sd1);
        send_request(ACT_RANGE, WORD_MAX - 32'sd1, WORD_MAX);
        send_request(ACT_RANGE, -32'sd1000000000, 32'sd2000000000);
        send_request(ACT_RANGE, 32'sd0, WORD_MAX);

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_TAIL)
                idling_on = 1'b0;
            else if (i % 40 == 0)
                idling_on = ($urandom_range(0, 2) != 0);
            if (i == HOLD_AT) begin
                // sink holds off while requests keep coming back to back
                idling_on      = 1'b0;
                hold_off_start = 1'b1;
            end
            send_random_request();
        end
        req_bus.valid <= 1'b0;

        do @(posedge i_clk); while (draws_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && draws_outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
